/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the sprite projection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clk edge while out of reset.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Expression must never be true on a clk edge while out of reset.
`define ASSERT_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

/* rtl/ssp_pkg.sv */
// Package for the sprite projection block: widths, defaults, status codes, payload types.
package ssp_pkg;

	localparam int SCREEN_WIDTH_DEF  = 640;
	localparam int SCREEN_HEIGHT_DEF = 480;

	localparam int S_DATA_W = 304;
	localparam int M_DATA_W = 168;
	localparam int M_USER_W = 2;

	typedef enum logic [1:0] {
		ST_FRONT  = 2'd0,
		ST_BEHIND = 2'd1,
		ST_DEGEN  = 2'd2
	} status_t;

	// sign and overflow of one quotient lane
	typedef struct packed {
		logic neg;
		logic ovf;
	} qflag_t;

	// side data riding along the camera-space divider
	typedef struct packed {
		logic               y_neg;
		logic               y_ovf;
		logic               dz;
		logic signed [13:0] pitch;
		logic               eye_neg;
		logic [31:0]        eye_mag;
	} p1_pay_t;

	// side data riding along one of the screen-space dividers
	typedef struct packed {
		logic               eye_neg;
		logic               eye_ovf;
		logic               front;
		logic               dz;
		logic signed [31:0] ty;
		logic signed [13:0] pitch;
	} p2_pay_t;

endpackage

/* rtl/sprite_screen_projection.sv */
// Sprite screen projection: takes a camera and one sprite position per input transaction
// and returns one result transaction with the camera-space depth, screen column, projected
// size, vertical shift and clamped draw bounds. The block accepts one transaction every
// clock cycle unless the output is stalled; each result passes through a 32-stage
// restoring divider for the camera transform and then through three parallel
// 17-stage dividers for column, size and shift. A stalled output holds the whole pipeline
// in place; s_tready follows m_tready combinationally through the stall logic.
`include "assert_macros.svh"

module sprite_screen_projection #(
	parameter int SCREEN_WIDTH  = ssp_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = ssp_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// player_x, player_y, dir_x, dir_y, plane_x, plane_y, pitch_rows, eye_height,
	// sprite_x, sprite_y
	input  logic [ssp_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// depth, screen_column, sprite_size, vertical_shift, start_x, end_x, start_y,
	// end_y, mid_x
	output logic [ssp_pkg::M_DATA_W-1:0]  m_tdata,
	// status
	output logic [ssp_pkg::M_USER_W-1:0]  m_tuser
);

	import ssp_pkg::*;

	localparam int HALF_W  = SCREEN_WIDTH / 2;
	localparam int HALF_H  = SCREEN_HEIGHT / 2;
	localparam int HW_BITS = $clog2(HALF_W + 1);
	localparam int CN_W    = 33 + HW_BITS;
	localparam logic [16:0] SZ_LOW = 17'((SCREEN_HEIGHT % 2) * 65536);
	localparam logic signed [18:0] SW_L  = 19'(SCREEN_WIDTH);
	localparam logic signed [18:0] SH_L  = 19'(SCREEN_HEIGHT);
	localparam logic signed [18:0] HH_L  = 19'(HALF_H);

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return d[31:0];
	endfunction

	function automatic logic signed [31:0] qsat(input logic [31:0] q, input logic neg,
		input logic ovf);
		if (ovf || q[31]) begin
			return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return neg ? -$signed(q) : $signed(q);
	endfunction

	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// input fields
	logic signed [31:0] in_px, in_py, in_dx, in_dy, in_plx, in_ply, in_eye, in_spx, in_spy;
	logic signed [13:0] in_pitch;
	assign in_px    = s_tdata[31:0];
	assign in_py    = s_tdata[63:32];
	assign in_dx    = s_tdata[95:64];
	assign in_dy    = s_tdata[127:96];
	assign in_plx   = s_tdata[159:128];
	assign in_ply   = s_tdata[191:160];
	assign in_pitch = s_tdata[205:192];
	assign in_eye   = s_tdata[237:206];
	assign in_spx   = s_tdata[269:238];
	assign in_spy   = s_tdata[301:270];

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	logic v_tx_o, v_ty_o, v_col_o, v_sz_o, v_eye_o;

	// stage 1..5: offsets, determinant, numerators, magnitudes, overflow checks
	logic signed [31:0] ox_s1, oy_s1, dx_s1, dy_s1, plx_s1, ply_s1, eye_s1;
	logic signed [13:0] pitch_s1;
	logic signed [63:0] pd1_s1, pd2_s1;

	logic signed [63:0] det_s2, pa_s2, pb_s2, pc_s2, pe_s2;
	logic signed [31:0] eye_s2;
	logic signed [13:0] pitch_s2;

	logic signed [63:0] det_s3, nx_s3, ny_s3;
	logic               dz_s3;
	logic signed [31:0] eye_s3;
	logic signed [13:0] pitch_s3;

	logic [63:0]        nxm_s4, nym_s4, dm_s4;
	logic               xneg_s4, yneg_s4, dz_s4, eye_neg_s4;
	logic [31:0]        eye_mag_s4;
	logic signed [13:0] pitch_s4;

	logic [63:0]        nxm_s5, nym_s5, dm_s5;
	qflag_t             fx_s5;
	p1_pay_t            p1_s5;

	// camera-space dividers
	logic [31:0] qx_o, qy_o;
	qflag_t      fx_o;
	p1_pay_t     p1_o;

	// stage 6..10: tx/ty, column numerator, overflow checks
	logic signed [31:0] tx_s6, ty_s6;
	p1_pay_t            p1_s6;

	logic signed [32:0] sum_s7;
	logic signed [31:0] ty_s7;
	logic               front_s7;
	p1_pay_t            p1_s7;

	logic [32:0]        smag_s8;
	logic               sneg_s8;
	logic signed [31:0] ty_s8;
	logic               front_s8;
	p1_pay_t            p1_s8;

	logic [CN_W-1:0]    cnum_s9;
	logic               sneg_s9;
	logic signed [31:0] ty_s9;
	logic               front_s9;
	p1_pay_t            p1_s9;

	logic [CN_W-1:0]    cnum_s10;
	logic [30:0]        den_s10;
	logic [31:0]        eye_mag_s10;
	qflag_t             fc_s10;
	logic               szovf_s10;
	p2_pay_t            p2_s10;

	// screen-space dividers
	logic [16:0] qc_o, qs_o, qe_o;
	qflag_t      fc_o;
	logic        szovf_o;
	p2_pay_t     p2_o;

	// stage 11..13: saturation, bounds, output register
	logic signed [16:0] col_s11, vsh_s11;
	logic [15:0]        size_s11;
	p2_pay_t            p2_s11;

	logic signed [16:0] col_s12, vsh_s12, ex_s12, ey_s12;
	logic [15:0]        size_s12, sx_s12, sy_s12;
	p2_pay_t            p2_s12;

	status_t            status_s13;
	logic signed [31:0] depth_s13;
	logic signed [16:0] col_s13, vsh_s13, ex_s13, ey_s13, mid_s13;
	logic [15:0]        size_s13, sx_s13, sy_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (adv) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_ty_o;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_eye_o;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// offsets and determinant products
			ox_s1    <= sat_sub(in_spx, in_px);
			oy_s1    <= sat_sub(in_spy, in_py);
			pd1_s1   <= 64'(in_plx) * 64'(in_dy);
			pd2_s1   <= 64'(in_dx) * 64'(in_ply);
			dx_s1    <= in_dx;
			dy_s1    <= in_dy;
			plx_s1   <= in_plx;
			ply_s1   <= in_ply;
			eye_s1   <= in_eye;
			pitch_s1 <= in_pitch;

			det_s2   <= pd1_s1 - pd2_s1;
			pa_s2    <= 64'(dy_s1) * 64'(ox_s1);
			pb_s2    <= 64'(dx_s1) * 64'(oy_s1);
			pc_s2    <= 64'(plx_s1) * 64'(oy_s1);
			pe_s2    <= 64'(ply_s1) * 64'(ox_s1);
			eye_s2   <= eye_s1;
			pitch_s2 <= pitch_s1;

			det_s3   <= det_s2;
			nx_s3    <= pa_s2 - pb_s2;
			ny_s3    <= pc_s2 - pe_s2;
			dz_s3    <= det_s2 == '0;
			eye_s3   <= eye_s2;
			pitch_s3 <= pitch_s2;

			nxm_s4     <= nx_s3[63] ? 64'(-nx_s3) : 64'(nx_s3);
			nym_s4     <= ny_s3[63] ? 64'(-ny_s3) : 64'(ny_s3);
			dm_s4      <= det_s3[63] ? 64'(-det_s3) : 64'(det_s3);
			xneg_s4    <= nx_s3[63] ^ det_s3[63];
			yneg_s4    <= ny_s3[63] ^ det_s3[63];
			dz_s4      <= dz_s3;
			eye_neg_s4 <= eye_s3[31];
			eye_mag_s4 <= eye_s3[31] ? 32'(-eye_s3) : 32'(eye_s3);
			pitch_s4   <= pitch_s3;

			// quotient reaches 2^32 exactly when n >= d * 2^16
			nxm_s5        <= nxm_s4;
			nym_s5        <= nym_s4;
			dm_s5         <= dm_s4;
			fx_s5.neg     <= xneg_s4;
			fx_s5.ovf     <= {16'b0, nxm_s4} >= {dm_s4, 16'b0};
			p1_s5.y_neg   <= yneg_s4;
			p1_s5.y_ovf   <= {16'b0, nym_s4} >= {dm_s4, 16'b0};
			p1_s5.dz      <= dz_s4;
			p1_s5.pitch   <= pitch_s4;
			p1_s5.eye_neg <= eye_neg_s4;
			p1_s5.eye_mag <= eye_mag_s4;

			tx_s6 <= qsat(qx_o, fx_o.neg, fx_o.ovf);
			ty_s6 <= qsat(qy_o, p1_o.y_neg, p1_o.y_ovf);
			p1_s6 <= p1_o;

			sum_s7   <= {tx_s6[31], tx_s6} + {ty_s6[31], ty_s6};
			ty_s7    <= ty_s6;
			front_s7 <= !ty_s6[31] && (ty_s6 != '0);
			p1_s7    <= p1_s6;

			smag_s8  <= sum_s7[32] ? 33'(-sum_s7) : 33'(sum_s7);
			sneg_s8  <= sum_s7[32];
			ty_s8    <= ty_s7;
			front_s8 <= front_s7;
			p1_s8    <= p1_s7;

			cnum_s9  <= CN_W'(smag_s8) * CN_W'(HALF_W);
			sneg_s9  <= sneg_s8;
			ty_s9    <= ty_s8;
			front_s9 <= front_s8;
			p1_s9    <= p1_s8;

			// screen-space quotients reach 2^17 exactly when n >= ty * 2^17
			cnum_s10       <= cnum_s9;
			den_s10        <= ty_s9[30:0];
			eye_mag_s10    <= p1_s9.eye_mag;
			fc_s10.neg     <= sneg_s9;
			fc_s10.ovf     <= 64'(cnum_s9) >= (64'(ty_s9[30:0]) << 17);
			szovf_s10      <= 32'(ty_s9[30:0]) <= 32'(HALF_H);
			p2_s10.eye_neg <= p1_s9.eye_neg;
			p2_s10.eye_ovf <= 64'(p1_s9.eye_mag) >= (64'(ty_s9[30:0]) << 17);
			p2_s10.front   <= front_s9;
			p2_s10.dz      <= p1_s9.dz;
			p2_s10.ty      <= ty_s9;
			p2_s10.pitch   <= p1_s9.pitch;
		end
	end

	ssp_div #(.DW(64), .QW(32), .PW($bits(qflag_t))) u_div_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s5),
		.in_rem   (64'(nxm_s5[63:16])),
		.in_den   (dm_s5),
		.in_num   ({nxm_s5[15:0], 16'b0}),
		.in_pay   (fx_s5),
		.out_valid(v_tx_o),
		.out_quo  (qx_o),
		.out_pay  (fx_o)
	);

	ssp_div #(.DW(64), .QW(32), .PW($bits(p1_pay_t))) u_div_ty (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s5),
		.in_rem   (64'(nym_s5[63:16])),
		.in_den   (dm_s5),
		.in_num   ({nym_s5[15:0], 16'b0}),
		.in_pay   (p1_s5),
		.out_valid(v_ty_o),
		.out_quo  (qy_o),
		.out_pay  (p1_o)
	);

	ssp_div #(.DW(31), .QW(17), .PW($bits(qflag_t))) u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s10),
		.in_rem   (31'(cnum_s10 >> 17)),
		.in_den   (den_s10),
		.in_num   (cnum_s10[16:0]),
		.in_pay   (fc_s10),
		.out_valid(v_col_o),
		.out_quo  (qc_o),
		.out_pay  (fc_o)
	);

	ssp_div #(.DW(31), .QW(17), .PW(1)) u_div_size (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s10),
		.in_rem   (31'(HALF_H)),
		.in_den   (den_s10),
		.in_num   (SZ_LOW),
		.in_pay   (szovf_s10),
		.out_valid(v_sz_o),
		.out_quo  (qs_o),
		.out_pay  (szovf_o)
	);

	ssp_div #(.DW(31), .QW(17), .PW($bits(p2_pay_t))) u_div_eye (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s10),
		.in_rem   (31'(eye_mag_s10 >> 17)),
		.in_den   (den_s10),
		.in_num   (eye_mag_s10[16:0]),
		.in_pay   (p2_s10),
		.out_valid(v_eye_o),
		.out_quo  (qe_o),
		.out_pay  (p2_o)
	);

	// saturate column, size and shift
	logic signed [16:0] col_c, vsh_c;
	logic [15:0]        size_c;
	logic signed [18:0] qe_c, vs_c;

	always_comb begin
		if (fc_o.ovf || qc_o[16]) begin
			col_c = fc_o.neg ? 17'sh10000 : 17'sh0FFFF;
		end else begin
			col_c = fc_o.neg ? -$signed({1'b0, qc_o[15:0]}) : $signed({1'b0, qc_o[15:0]});
		end
		size_c = (szovf_o || qs_o[16]) ? 16'hFFFF : qs_o[15:0];
		qe_c   = p2_o.eye_neg ? -$signed(19'(qe_o)) : $signed(19'(qe_o));
		vs_c   = 19'(p2_o.pitch) + qe_c;
		if (p2_o.eye_ovf) begin
			vsh_c = p2_o.eye_neg ? 17'sh10000 : 17'sh0FFFF;
		end else if (vs_c > 19'sd65535) begin
			vsh_c = 17'sh0FFFF;
		end else if (vs_c < -19'sd65536) begin
			vsh_c = 17'sh10000;
		end else begin
			vsh_c = vs_c[16:0];
		end
	end

	// draw bounds
	logic signed [18:0] half_c, colx_c, vshx_c, tsx_c, tex_c, tsy_c, tey_c;
	logic [15:0]        sx_c, sy_c;
	logic signed [16:0] ex_c, ey_c;

	always_comb begin
		half_c = $signed({4'b0, size_s11[15:1]});
		colx_c = 19'(col_s11);
		vshx_c = 19'(vsh_s11);
		tsx_c  = colx_c - half_c;
		tex_c  = colx_c + half_c;
		tsy_c  = HH_L - half_c + vshx_c;
		tey_c  = HH_L + half_c + vshx_c;
		if (tsx_c < 0) begin
			sx_c = 16'd0;
		end else if (tsx_c > 19'sd65535) begin
			sx_c = 16'hFFFF;
		end else begin
			sx_c = tsx_c[15:0];
		end
		if (tsy_c < 0) begin
			sy_c = 16'd0;
		end else if (tsy_c > 19'sd65535) begin
			sy_c = 16'hFFFF;
		end else begin
			sy_c = tsy_c[15:0];
		end
		ex_c = (tex_c >= SW_L) ? 17'(SW_L - 19'sd1) : tex_c[16:0];
		ey_c = (tey_c >= SH_L) ? 17'(SH_L - 19'sd1) : tey_c[16:0];
	end

	// midpoint, halving end_x toward zero
	logic signed [17:0] exs_c, mid_c;

	always_comb begin
		exs_c = ($signed({ex_s12[16], ex_s12}) + $signed({17'b0, ex_s12[16]})) >>> 1;
		mid_c = $signed({3'b0, sx_s12[15:1]}) + exs_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s11  <= col_c;
			size_s11 <= size_c;
			vsh_s11  <= vsh_c;
			p2_s11   <= p2_o;

			col_s12  <= col_s11;
			size_s12 <= size_s11;
			vsh_s12  <= vsh_s11;
			sx_s12   <= sx_c;
			ex_s12   <= ex_c;
			sy_s12   <= sy_c;
			ey_s12   <= ey_c;
			p2_s12   <= p2_s11;

			if (p2_s12.dz) begin
				status_s13 <= ST_DEGEN;
				depth_s13  <= '0;
			end else if (!p2_s12.front) begin
				status_s13 <= ST_BEHIND;
				depth_s13  <= p2_s12.ty;
			end else begin
				status_s13 <= ST_FRONT;
				depth_s13  <= p2_s12.ty;
			end
			// zero everything but depth unless the sprite is in front
			if (p2_s12.dz || !p2_s12.front) begin
				col_s13  <= '0;
				size_s13 <= '0;
				vsh_s13  <= '0;
				sx_s13   <= '0;
				ex_s13   <= '0;
				sy_s13   <= '0;
				ey_s13   <= '0;
				mid_s13  <= '0;
			end else begin
				col_s13  <= col_s12;
				size_s13 <= size_s12;
				vsh_s13  <= vsh_s12;
				sx_s13   <= sx_s12;
				ex_s13   <= ex_s12;
				sy_s13   <= sy_s12;
				ey_s13   <= ey_s12;
				mid_s13  <= mid_c[16:0];
			end
		end
	end

	assign m_tvalid = v_s13;
	assign m_tuser  = status_s13;
	assign m_tdata  = {3'b0, mid_s13, ey_s13, sy_s13, ex_s13, sx_s13, vsh_s13, size_s13,
		col_s13, depth_s13};

	`ASSERT_CLK(a_accept_enters_s1, s_tvalid && s_tready |=> v_s1, "accepted transaction lost at stage 1")
	`ASSERT_CLK(a_cam_div_lanes, v_tx_o == v_ty_o, "camera dividers out of step")
	`ASSERT_CLK(a_scr_div_lanes, v_col_o == v_eye_o && v_sz_o == v_eye_o, "screen dividers out of step")
	`ASSERT_NEVER(a_degen_depth, m_tvalid && m_tuser == ST_DEGEN && m_tdata[31:0] != '0, "degenerate camera with nonzero depth")

endmodule

/* rtl/ssp_div.sv */
// Pipelined restoring divider, one quotient bit per register stage, with side payload.
module ssp_div #(
	parameter int DW = 64,
	parameter int QW = 32,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] in_rem,
	input  logic [DW-1:0] in_den,
	input  logic [QW-1:0] in_num,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic [PW-1:0] out_pay
);

	logic          vld_s [QW];
	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] num_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [PW-1:0] pay_s [QW];

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_stage
			logic          vi;
			logic [DW-1:0] ri;
			logic [DW-1:0] di;
			logic [QW-1:0] ni;
			logic [QW-1:0] qi;
			logic [PW-1:0] pi;
			logic [DW:0]   trial;
			logic          ge;

			if (k == 0) begin : g_first
				assign vi = in_valid;
				assign ri = in_rem;
				assign di = in_den;
				assign ni = in_num;
				assign qi = '0;
				assign pi = in_pay;
			end else begin : g_next
				assign vi = vld_s[k-1];
				assign ri = rem_s[k-1];
				assign di = den_s[k-1];
				assign ni = num_s[k-1];
				assign qi = quo_s[k-1];
				assign pi = pay_s[k-1];
			end

			// shift in the next dividend bit, subtract when it fits
			assign trial = {ri, ni[QW-1-k]};
			assign ge    = trial >= {1'b0, di};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= vi;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? DW'(trial - {1'b0, di}) : DW'(trial);
					den_s[k] <= di;
					num_s[k] <= ni;
					quo_s[k] <= {qi[QW-2:0], ge};
					pay_s[k] <= pi;
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_pay   = pay_s[QW-1];

endmodule

/* bench/tb.sv */
// Self-checking bench for the sprite screen projection block.
`timescale 1ns / 100ps

module tb;
	import ssp_pkg::*;

	localparam int SW = SCREEN_WIDTH_DEF;
	localparam int SH = SCREEN_HEIGHT_DEF;
	localparam int N_RANDOM = 1500;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		status_t     status;
		logic [31:0] depth;
		logic [16:0] column;
		logic [15:0] size;
		logic [16:0] vshift;
		logic [15:0] sx;
		logic [16:0] ex;
		logic [15:0] sy;
		logic [16:0] ey;
		logic [16:0] mid;
	} proj_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;

	logic [S_DATA_W-1:0] camera_q[$];
	proj_t projection_q[$];
	int errors = 0;
	int cycle = 0;
	int quiet_cycles = 0;

	sprite_screen_projection dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [127:0] sat128(logic signed [127:0] v,
			logic signed [127:0] lo, logic signed [127:0] hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// trunc(num * 2^16 / den) saturated to signed Q16.16
	function automatic logic signed [127:0] q16_quot(logic signed [127:0] num,
			logic signed [127:0] den);
		logic signed [127:0] q;
		q = (num * 128'sd65536) / den;
		return sat128(q, -128'sd2147483648, 128'sd2147483647);
	endfunction

	function automatic proj_t project(logic [S_DATA_W-1:0] d);
		logic signed [127:0] px, py, dx0, dy0, plx, ply, pitch, eye, spx, spy;
		logic signed [127:0] ox, oy, det, tx, ty, col, size, vsh, sx, ex, sy, ey, half;
		proj_t r;
		px = $signed(d[31:0]);     py = $signed(d[63:32]);
		dx0 = $signed(d[95:64]);   dy0 = $signed(d[127:96]);
		plx = $signed(d[159:128]); ply = $signed(d[191:160]);
		pitch = $signed(d[205:192]);
		eye = $signed(d[237:206]);
		spx = $signed(d[269:238]); spy = $signed(d[301:270]);
		r = '{status: ST_FRONT, default: '0};
		ox = sat128(spx - px, -128'sd2147483648, 128'sd2147483647);
		oy = sat128(spy - py, -128'sd2147483648, 128'sd2147483647);
		det = plx * dy0 - dx0 * ply;
		if (det == 0) begin
			r.status = ST_DEGEN;
			return r;
		end
		tx = q16_quot(dy0 * ox - dx0 * oy, det);
		ty = q16_quot(plx * oy - ply * ox, det);
		r.depth = ty[31:0];
		if (ty <= 0) begin
			r.status = ST_BEHIND;
			return r;
		end
		col = sat128((SW / 2) * (ty + tx) / ty, -65536, 65535);
		size = sat128((SH * 128'sd65536) / ty, 0, 65535);
		vsh = sat128(pitch + eye / ty, -65536, 65535);
		half = size / 2;
		sy = sat128(SH / 2 - half + vsh, 0, 65535);
		ey = half + SH / 2 + vsh;
		if (ey >= SH) ey = SH - 1;
		sx = sat128(col - half, 0, 65535);
		ex = half + col;
		if (ex >= SW) ex = SW - 1;
		r.column = col[16:0];
		r.size = size[15:0];
		r.vshift = vsh[16:0];
		r.sx = sx[15:0];
		r.ex = ex[16:0];
		r.sy = sy[15:0];
		r.ey = ey[16:0];
		r.mid = 17'(sx / 2 + ex / 2);
		return r;
	endfunction

	function automatic logic [S_DATA_W-1:0] pack_camera(int px, int py, int dx, int dy,
			int plx, int ply, logic [13:0] pitch, int eye, int spx, int spy);
		return {2'b00, spy, spx, eye, pitch, ply, plx, dy, dx, py, px};
	endfunction

	function automatic int small_q(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// mostly plausible cameras with sprites nearby; the rest raw noise
	function automatic logic [S_DATA_W-1:0] random_camera();
		int px, py;
		if ($urandom_range(0, 3) == 0)
			return pack_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				14'($urandom), $urandom, $urandom, $urandom);
		px = small_q(1 << 24);
		py = small_q(1 << 24);
		return pack_camera(px, py, small_q(1 << 17), small_q(1 << 17), small_q(1 << 17),
			small_q(1 << 17), 14'(small_q(4096)), small_q(1 << 22),
			px + small_q(1 << 22), py + small_q(1 << 22));
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	// driver: push the prediction when a transaction is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) projection_q.push_back(project(s_tdata));
			if (!s_tvalid || s_tready) begin
				if (camera_q.size() > 0 &&
						((cycle > 1500 && cycle < 2500) || $urandom_range(0, 99) >= 9)) begin
					s_tvalid <= 1'b1;
					s_tdata <= camera_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker; hold off for a long stretch once
	always @(posedge clk or negedge arst_n) begin
		proj_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			cycle <= cycle + 1;
			if (m_tvalid && m_tready) begin
				if (projection_q.size() == 0) begin
					$error("result with no pending projection");
					errors++;
				end else begin
					e = projection_q.pop_front();
					check_field("status", 32'(e.status), 32'(m_tuser));
					check_field("depth", e.depth, m_tdata[31:0]);
					check_field("screen_column", 32'(e.column), 32'(m_tdata[48:32]));
					check_field("sprite_size", 32'(e.size), 32'(m_tdata[64:49]));
					check_field("vertical_shift", 32'(e.vshift), 32'(m_tdata[81:65]));
					check_field("start_x", 32'(e.sx), 32'(m_tdata[97:82]));
					check_field("end_x", 32'(e.ex), 32'(m_tdata[114:98]));
					check_field("start_y", 32'(e.sy), 32'(m_tdata[130:115]));
					check_field("end_y", 32'(e.ey), 32'(m_tdata[147:131]));
					check_field("mid_x", 32'(e.mid), 32'(m_tdata[164:148]));
				end
			end
			if (cycle >= 600 && cycle < 1000)
				m_tready <= 1'b0;
			else
				m_tready <= (cycle > 1500 && cycle < 2500) || $urandom_range(0, 99) >= 9;
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int one;
		one = 1 << 16;
		arst_n = 1'b0;
		// degenerate camera, behind, straight ahead, extremes
		camera_q.push_back(pack_camera(0, 0, 0, 0, 0, 0, 14'd0, 0, 0, 0));
		camera_q.push_back(pack_camera(0, 0, one, 0, 0, one, 14'd0, 0, 0, 0));
		camera_q.push_back(pack_camera(0, 0, one, 0, 0, 43253, 14'd0, 0, 5 * one, 0));
		camera_q.push_back(pack_camera(0, 0, one, 0, 0, 43253, 14'd0, 0, -5 * one, 0));
		camera_q.push_back(pack_camera(0, 0, 0, one, -one, 0, 14'd100, one, one, 2 * one));
		camera_q.push_back(pack_camera(0, 0, 0, one, -one, 0, 14'h1FFF, 32'h7FFFFFFF,
			0, 3 * one));
		camera_q.push_back(pack_camera(0, 0, 0, one, -one, 0, 14'h2000, 32'h80000000,
			0, 3 * one));
		camera_q.push_back(pack_camera(0, 0, 0, one, -one, 0, 14'd0, 0, 0, 1));
		camera_q.push_back(pack_camera(0, 0, 0, one, -one, 0, 14'd0, 0, 0, 0));
		camera_q.push_back(pack_camera(32'h80000000, 32'h80000000, 0, one, -one, 0,
			14'd0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF));
		camera_q.push_back(pack_camera(32'h7FFFFFFF, 32'h7FFFFFFF, 0, one, -one, 0,
			14'd0, 0, 32'h80000000, 32'h80000000));
		camera_q.push_back(pack_camera(0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 14'd0, 0, one, one));
		camera_q.push_back(pack_camera(0, 0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 14'd5, one, 32'h7FFFFFFF, 32'h80000000));
		camera_q.push_back(pack_camera(0, 0, 1, 0, 0, 1, 14'd0, 0, 32'h7FFFFFFF, 0));
		camera_q.push_back(pack_camera(0, 0, 0, one, -one, 0, 14'd0, 0, 50 * one, 8 * one));
		camera_q.push_back(pack_camera(0, 0, 0, one, -one, 0, 14'd0, 0, -50 * one, 8 * one));
		camera_q.push_back(pack_camera(-1, -1, -1, -1, -1, 1, 14'h3FFF, -1, -1, -1));
		for (int i = 0; i < N_RANDOM; i++) camera_q.push_back(random_camera());
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// hold until every transaction is sent and every result is checked
		while (camera_q.size() != 0 || s_tvalid) @(posedge clk);
		while (projection_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && projection_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
